@@ sv/ilid_pkg.sv @@
package ilid_pkg;

    localparam int CAPACITY_DEF = 32;

    localparam logic [2:0] REQ_GET  = 3'd0;
    localparam logic [2:0] REQ_HEAD = 3'd1;
    localparam logic [2:0] REQ_TAIL = 3'd2;
    localparam logic [2:0] REQ_AT   = 3'd3;
    localparam logic [2:0] REQ_DEL  = 3'd4;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [5:0]         position;
        logic signed [31:0] new_value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [5:0]         entry_count;
    } rsp_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
    } cell_ctrl_t;

endpackage

@@ sv/ilid_cell.sv @@
module ilid_cell
    import ilid_pkg::*;
#(
    parameter int PW  = 6,
    parameter int IDX = 0
)
(
    input  logic                  clk,
    input  cell_ctrl_t            ctrl,
    input  logic [PW-1:0]         pos,
    input  logic signed [31:0]    new_value,
    input  logic signed [31:0]    prev_value,
    input  logic signed [31:0]    next_value,
    output logic signed [31:0]    value,
    output logic signed [31:0]    rd_value
);

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins)
        begin
            if (pos == MY_IDX)
            begin
                value_next = new_value;
            end
            else if (pos < MY_IDX)
            begin
                value_next = prev_value;
            end
        end
        else if (ctrl.del && (pos <= MY_IDX))
        begin
            value_next = next_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value    = value_reg;
    // gated so the top can OR all cells together
    assign rd_value = (pos == MY_IDX) ? value_reg : '0;

endmodule

@@ sv/indexed_list_insert_delete.sv @@
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells.
// A request is taken on any cycle with start high; busy is always low, so one
// request can be issued every clock. Its result appears on rsp with done high
// for exactly one cycle, on the cycle after the request; the receiver cannot
// stall it and must capture it then. Inserts and deletes move every later
// entry by one place in that single cycle, each cell loading from its
// neighbor; reads select the addressed cell through an OR tree across the row.
// Entries past the current count hold stale data and are never returned.
module indexed_list_insert_delete
    import ilid_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 6) ? CW : 6;
    localparam logic [PW-1:0] CAP_W = PW'(CAPACITY);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          done_reg;
    rsp_t          rsp_reg;
    rsp_t          rsp_next;

    cell_ctrl_t    ctrl;
    logic [PW-1:0] cell_pos;
    logic [PW-1:0] count_w;
    logic [PW-1:0] req_pos;
    logic          full;
    logic signed [31:0] rd_or;

    logic signed [31:0] cell_val [CAPACITY];
    logic signed [31:0] cell_rd  [CAPACITY];

    assign count_w = PW'(count_reg);
    assign req_pos = PW'(req.position);
    assign full    = (count_w == CAP_W);

    // slot the row acts on: head and tail inserts ignore the position field
    always_comb
    begin
        cell_pos = req_pos;
        if (req.req_type == REQ_HEAD)
        begin
            cell_pos = '0;
        end
        else if (req.req_type == REQ_TAIL)
        begin
            cell_pos = count_w;
        end
    end

    always_comb
    begin
        ctrl       = '0;
        count_next = count_reg;
        rsp_next   = '0;
        case (req.req_type)
            REQ_GET:
            begin
                if (req_pos < count_w)
                begin
                    rsp_next.read_value = rd_or;
                end
                else
                begin
                    rsp_next.read_value = -32'sd1;
                    rsp_next.status     = ST_RANGE;
                end
            end
            REQ_HEAD, REQ_TAIL, REQ_AT:
            begin
                if ((req.req_type == REQ_AT) && (req_pos > count_w))
                begin
                    rsp_next.status = ST_RANGE;
                end
                else if (full)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    ctrl.ins   = start;
                    count_next = count_reg + CW'(1);
                end
            end
            REQ_DEL:
            begin
                if (req_pos >= count_w)
                begin
                    rsp_next.status = ST_RANGE;
                end
                else
                begin
                    ctrl.del   = start;
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                rsp_next.status = ST_RANGE;
            end
        endcase
        rsp_next.entry_count = 6'(count_next);
    end

    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_or = rd_or | cell_rd[i];
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [31:0] prev_v;
        logic signed [31:0] next_v;
        if (g == 0)
        begin : g_first
            assign prev_v = req.new_value;
        end
        else
        begin : g_mid
            assign prev_v = cell_val[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_last
            assign next_v = cell_val[g];
        end
        else
        begin : g_inner
            assign next_v = cell_val[g+1];
        end
        ilid_cell #(
            .PW  (PW),
            .IDX (g)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .pos        (cell_pos),
            .new_value  (req.new_value),
            .prev_value (prev_v),
            .next_value (next_v),
            .value      (cell_val[g]),
            .rd_value   (cell_rd[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= start;
            if (start)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign busy = 1'b0;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> done)
        else $error("result strobe missing after request");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        PW'(count_reg) <= CAP_W)
        else $error("entry count above capacity");

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !start |=> $stable(count_reg))
        else $error("entry count moved without a request");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        start && full && (req.req_type == REQ_HEAD || req.req_type == REQ_TAIL)
        |=> rsp.status == ST_FULL && $stable(count_reg))
        else $error("insert into full list not dropped");

endmodule
